// ----- rtl/serial_command_frame_parser_unit_macros.svh -----
// Assertion macros for the serial command frame parser.
// Used by the top level; no other dependencies.
`ifndef SERIAL_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`ifndef SYNTH
`define SCFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scfp: implication check failed");
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scfp: next-cycle check failed");
`else
`define SCFP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/scfp_pkg.sv -----
// Package for the serial command frame parser: codes, constants, state type.
// No dependencies.
`default_nettype none
package scfp_pkg;
   localparam int SCFP_FRAME_DEPTH = 64;
   localparam int SCFP_IDX_W       = 9;

   localparam logic [7:0] BYTE_HS_START = 8'hFE;
   localparam logic [7:0] BYTE_HS_FF    = 8'hFF;
   localparam logic [7:0] BYTE_SOF      = 8'hFC;
   localparam logic [7:0] BYTE_EOF      = 8'hFD;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_MEGA     = 8'h4D;
   localparam logic [7:0] CHAR_KILO     = 8'h4B;

   localparam logic [7:0] CMD_PASS_ON  = 8'h00;
   localparam logic [7:0] CMD_PSW_ON   = 8'h01;
   localparam logic [7:0] CMD_PSW_OFF  = 8'h02;
   localparam logic [7:0] CMD_PASS_OFF = 8'h03;
   localparam logic [7:0] CMD_DSW_ON   = 8'h04;
   localparam logic [7:0] CMD_DSW_OFF  = 8'h05;
   localparam logic [7:0] CMD_DAC      = 8'h0A;
   localparam logic [7:0] CMD_DDS_AMP  = 8'h0B;
   localparam logic [7:0] CMD_DDS_FREQ = 8'h0D;
   localparam logic [7:0] CMD_ATTEN    = 8'h0E;
   localparam logic [7:0] CMD_PLL_FREQ = 8'h0F;

   localparam logic [2:0] KIND_READY = 3'd0;
   localparam logic [2:0] KIND_PLL   = 3'd1;
   localparam logic [2:0] KIND_DAC   = 3'd2;
   localparam logic [2:0] KIND_DDS   = 3'd3;
   localparam logic [2:0] KIND_AMP   = 3'd4;
   localparam logic [2:0] KIND_ATTEN = 3'd5;
   localparam logic [2:0] KIND_FLAG  = 3'd6;

   localparam logic [19:0] SCALE_MEGA_INT  = 20'd1000000;
   localparam logic [19:0] SCALE_MEGA_FRAC = 20'd100000;
   localparam logic [19:0] SCALE_KILO_INT  = 20'd1000;
   localparam logic [19:0] SCALE_KILO_FRAC = 20'd100;

   typedef enum logic [4:0] {
      S_IDLE, S_CMD_RD, S_CMD_USE, S_SWP_RD, S_SWP_USE, S_SCAN_RD, S_SCAN_USE,
      S_SUM_INIT, S_SUM_CHK, S_SUM_RD, S_SUM_USE, S_POST, S_TEN_RD, S_TEN_USE,
      S_UNIT_SET, S_UNIT_RD, S_UNIT_USE, S_MUL_IP, S_MUL_TEN, S_ADD, S_OUT
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/scfp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module scfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/serial_command_frame_parser_unit.sv -----
// Serial command frame parser top level: sequencer, frame buffer, shared multiplier.
// Depends on scfp_pkg, scfp_ram and serial_command_frame_parser_unit_macros.svh.
//
// Usage:
//  req_* carries one received byte per word; rsp_* carries at most one result
//  per byte. A word moves when valid is high and stall is low.
//  The handshake FE FF FF FF yields a ready result on its last byte. An FD
//  closing a frame starts a walk of the frame buffer through one registered
//  RAM read port: S_SCAN_RD and S_SCAN_USE per byte in the scan for the dot,
//  S_SUM_CHK, S_SUM_RD and S_SUM_USE per digit in the digit sum, then the
//  multiplier states S_MUL_IP, S_MUL_TEN and S_ADD for a DDS frequency with
//  an M or K unit, and last the result state S_OUT.
//  req_stall is high while a frame is decoded and while a result waits;
//  a stalled result holds its value until taken.
//  Reset (synchronous) clears all flags, counters and the buffer valid bits,
//  so unwritten buffer entries read as zero. No clearing pass is needed.
`default_nettype none
`include "serial_command_frame_parser_unit_macros.svh"
module serial_command_frame_parser_unit
   import scfp_pkg::*;
#(
   parameter int FRAME_DEPTH = SCFP_FRAME_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [7:0]       rsp_command_code,
   output logic [31:0]      rsp_value,
   output logic [7:0]       rsp_tenths_digit,
   output logic             rsp_passthrough_on,
   output logic             rsp_pll_sweep_on,
   output logic [7:0]       rsp_pll_sweep_time,
   output logic             rsp_dds_sweep_on,
   output logic [7:0]       rsp_dds_sweep_time,
   output logic             rsp_link_ready
);
   localparam int AW = $clog2(FRAME_DEPTH);
   localparam int IW = SCFP_IDX_W;

   state_type state_ff, state_in;

   logic                   armed_ff, armed_in;
   logic [1:0]             ffc_ff, ffc_in;
   logic                   inf_ff, inf_in;
   logic [7:0]             count_ff, count_in;
   logic [FRAME_DEPTH-1:0] valid_ff, valid_in;
   logic                   link_ff, link_in;
   logic                   pass_ff, pass_in;
   logic                   psw_ff, psw_in;
   logic                   dsw_ff, dsw_in;
   logic [7:0]             sweep_ff, sweep_in;

   logic [7:0]    n_ff, n_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [2:0]    kind_ff, kind_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [7:0]    dot_ff, dot_in;
   logic [15:0]   acc_ff, acc_in;
   logic [7:0]    ten_ff, ten_in;
   logic [31:0]   val_ff, val_in;
   logic [31:0]   mul_ff, mul_in;
   logic          mega_ff, mega_in;

   logic          accept;
   logic          wr_en;
   logic [7:0]    rdata;
   logic [7:0]    rd_val;
   logic          hs_done;
   logic          frame_end;
   logic [IW-1:0] n_ext;
   logic [15:0]   mul_a;
   logic [19:0]   mul_b;
   logic [35:0]   prod;

   assign accept = req_valid && !req_stall;
   assign n_ext  = {{(IW-8){1'b0}}, n_ff};

   scfp_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rdata)
   );

   always_comb begin
      rd_val = 8'h00;
      if (addr_ff < IW'(FRAME_DEPTH) && valid_ff[addr_ff[AW-1:0]]) begin
         rd_val = rdata;
      end
   end

   always_comb begin
      hs_done = 1'b0;
      if (armed_ff && req_rx_byte == BYTE_HS_FF && ffc_ff == 2'd2) begin
         hs_done = 1'b1;
      end
      frame_end = inf_ff && count_ff < 8'(FRAME_DEPTH) && req_rx_byte == BYTE_EOF;
      wr_en = accept && inf_ff && count_ff < 8'(FRAME_DEPTH) && req_rx_byte != BYTE_EOF;
   end

   assign mul_a = (state_ff == S_MUL_IP) ? acc_ff : {8'h00, ten_ff};
   always_comb begin
      if (state_ff == S_MUL_IP) begin
         mul_b = mega_ff ? SCALE_MEGA_INT : SCALE_KILO_INT;
      end else begin
         mul_b = mega_ff ? SCALE_MEGA_FRAC : SCALE_KILO_FRAC;
      end
   end
   assign prod = {20'h00000, mul_a} * {16'h0000, mul_b};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && frame_end) begin
               state_in = S_CMD_RD;
            end else if (accept && hs_done) begin
               state_in = S_OUT;
            end
         end
         S_CMD_RD:   state_in = S_CMD_USE;
         S_CMD_USE:  state_in = S_SWP_RD;
         S_SWP_RD:   state_in = S_SWP_USE;
         S_SWP_USE: begin
            case (cmd_ff)
               CMD_PLL_FREQ, CMD_DDS_FREQ: begin
                  state_in = (n_ff <= 8'd1) ? S_SUM_INIT : S_SCAN_RD;
               end
               CMD_DAC, CMD_DDS_AMP, CMD_ATTEN: state_in = S_SUM_INIT;
               default: state_in = S_OUT;
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_USE;
         S_SCAN_USE: begin
            if (rd_val == CHAR_DOT
                  || (cmd_ff == CMD_DDS_FREQ && addr_ff + IW'(2) == n_ext)
                  || addr_ff + IW'(1) >= n_ext) begin
               state_in = S_SUM_INIT;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SUM_INIT: state_in = S_SUM_CHK;
         S_SUM_CHK: begin
            state_in = (addr_ff < {1'b0, dot_ff}) ? S_SUM_RD : S_POST;
         end
         S_SUM_RD:   state_in = S_SUM_USE;
         S_SUM_USE:  state_in = S_SUM_CHK;
         S_POST: begin
            if (cmd_ff == CMD_PLL_FREQ) begin
               state_in = (dot_ff != n_ff) ? S_TEN_RD : S_OUT;
            end else if (cmd_ff == CMD_DDS_FREQ) begin
               state_in = (n_ff == 8'd0 || dot_ff != n_ff - 8'd1) ? S_TEN_RD : S_UNIT_SET;
            end else begin
               state_in = S_OUT;
            end
         end
         S_TEN_RD:   state_in = S_TEN_USE;
         S_TEN_USE:  state_in = (cmd_ff == CMD_PLL_FREQ) ? S_OUT : S_UNIT_SET;
         S_UNIT_SET: state_in = (n_ff == 8'd0) ? S_OUT : S_UNIT_RD;
         S_UNIT_RD:  state_in = S_UNIT_USE;
         S_UNIT_USE: begin
            state_in = (rd_val == CHAR_MEGA || rd_val == CHAR_KILO) ? S_MUL_IP : S_OUT;
         end
         S_MUL_IP:   state_in = S_MUL_TEN;
         S_MUL_TEN:  state_in = S_ADD;
         S_ADD:      state_in = S_OUT;
         S_OUT:      state_in = rsp_stall ? S_OUT : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      armed_in = armed_ff;
      ffc_in   = ffc_ff;
      inf_in   = inf_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      link_in  = link_ff;
      pass_in  = pass_ff;
      psw_in   = psw_ff;
      dsw_in   = dsw_ff;
      sweep_in = sweep_ff;
      n_in     = n_ff;
      cmd_in   = cmd_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      dot_in   = dot_ff;
      acc_in   = acc_ff;
      ten_in   = ten_ff;
      val_in   = val_ff;
      mul_in   = mul_ff;
      mega_in  = mega_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (armed_ff) begin
                  if (req_rx_byte == BYTE_HS_FF) begin
                     ffc_in = ffc_ff + 2'd1;
                  end else begin
                     ffc_in   = 2'd0;
                     armed_in = 1'b0;
                  end
                  if (hs_done) begin
                     ffc_in   = 2'd0;
                     armed_in = 1'b0;
                     link_in  = 1'b1;
                     kind_in  = KIND_READY;
                     cmd_in   = 8'h00;
                     val_in   = 32'd0;
                     ten_in   = 8'h00;
                  end
               end
               if (req_rx_byte == BYTE_HS_START) begin
                  armed_in = 1'b1;
               end
               if (inf_ff) begin
                  if (count_ff >= 8'(FRAME_DEPTH)) begin
                     inf_in   = 1'b0;
                     count_in = 8'd0;
                  end else if (frame_end) begin
                     n_in     = count_ff;
                     inf_in   = 1'b0;
                     count_in = 8'd0;
                     addr_in  = '0;
                  end else begin
                     valid_in[count_ff[AW-1:0]] = 1'b1;
                     count_in = count_ff + 8'd1;
                  end
               end
               if (req_rx_byte == BYTE_SOF) begin
                  inf_in = 1'b1;
               end
            end
         end
         S_CMD_USE: begin
            cmd_in  = rd_val;
            addr_in = IW'(1);
         end
         S_SWP_USE: begin
            sweep_in = rd_val - CHAR_ZERO;
            val_in   = 32'd0;
            ten_in   = 8'h00;
            dot_in   = n_ff;
            addr_in  = IW'(1);
            case (cmd_ff)
               CMD_PLL_FREQ: begin
                  kind_in = KIND_PLL;
                  if (n_ff <= 8'd1) begin
                     dot_in = 8'd0;
                  end
               end
               CMD_DDS_FREQ: begin
                  kind_in = KIND_DDS;
                  if (n_ff <= 8'd1) begin
                     dot_in = 8'd0;
                  end
               end
               CMD_DAC:     kind_in = KIND_DAC;
               CMD_DDS_AMP: kind_in = KIND_AMP;
               CMD_ATTEN:   kind_in = KIND_ATTEN;
               default: begin
                  kind_in = KIND_FLAG;
                  case (cmd_ff)
                     CMD_PASS_ON:  pass_in = 1'b1;
                     CMD_PASS_OFF: pass_in = 1'b0;
                     CMD_PSW_ON:   psw_in  = 1'b1;
                     CMD_PSW_OFF:  psw_in  = 1'b0;
                     CMD_DSW_ON:   dsw_in  = 1'b1;
                     CMD_DSW_OFF:  dsw_in  = 1'b0;
                     default:      pass_in = pass_ff;
                  endcase
               end
            endcase
         end
         S_SCAN_USE: begin
            if (rd_val == CHAR_DOT) begin
               dot_in = addr_ff[7:0];
            end else if (cmd_ff == CMD_DDS_FREQ && addr_ff + IW'(2) == n_ext) begin
               dot_in = n_ff - 8'd1;
            end else if (addr_ff + IW'(1) >= n_ext) begin
               dot_in = (cmd_ff == CMD_PLL_FREQ) ? n_ff : 8'd0;
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end
         S_SUM_INIT: begin
            acc_in  = 16'h0000;
            addr_in = IW'(1);
         end
         S_SUM_USE: begin
            acc_in  = (acc_ff << 3) + (acc_ff << 1) + {8'h00, rd_val} - {8'h00, CHAR_ZERO};
            addr_in = addr_ff + IW'(1);
         end
         S_POST: begin
            addr_in = {1'b0, dot_ff} + IW'(1);
            case (cmd_ff)
               CMD_DDS_AMP: val_in = {16'h0000, acc_ff[14:0], 1'b0};
               CMD_ATTEN:   val_in = {24'h000000, acc_ff[7:0]};
               default:     val_in = {16'h0000, acc_ff};
            endcase
         end
         S_TEN_USE: begin
            ten_in = rd_val - CHAR_ZERO;
         end
         S_UNIT_SET: begin
            addr_in = n_ext - IW'(1);
         end
         S_UNIT_USE: begin
            mega_in = (rd_val == CHAR_MEGA);
         end
         S_MUL_IP: begin
            mul_in = prod[31:0];
         end
         S_MUL_TEN: begin
            val_in = mul_ff;
            mul_in = prod[31:0];
         end
         S_ADD: begin
            val_in = val_ff + mul_ff;
         end
         default: begin
            mul_in = mul_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         armed_ff <= 1'b0;
         ffc_ff   <= 2'd0;
         inf_ff   <= 1'b0;
         count_ff <= 8'd0;
         valid_ff <= '0;
         link_ff  <= 1'b0;
         pass_ff  <= 1'b0;
         psw_ff   <= 1'b0;
         dsw_ff   <= 1'b0;
         sweep_ff <= 8'h00;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         ffc_ff   <= ffc_in;
         inf_ff   <= inf_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         link_ff  <= link_in;
         pass_ff  <= pass_in;
         psw_ff   <= psw_in;
         dsw_ff   <= dsw_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      cmd_ff  <= cmd_in;
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      dot_ff  <= dot_in;
      acc_ff  <= acc_in;
      ten_ff  <= ten_in;
      val_ff  <= val_in;
      mul_ff  <= mul_in;
      mega_ff <= mega_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_result_kind    = kind_ff;
   assign rsp_command_code   = cmd_ff;
   assign rsp_value          = val_ff;
   assign rsp_tenths_digit   = ten_ff;
   assign rsp_passthrough_on = pass_ff;
   assign rsp_pll_sweep_on   = psw_ff;
   assign rsp_pll_sweep_time = sweep_ff;
   assign rsp_dds_sweep_on   = dsw_ff;
   assign rsp_dds_sweep_time = sweep_ff;
   assign rsp_link_ready     = link_ff;

   `SCFP_ASSERT_IMPL(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall)
   `SCFP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= 8'(FRAME_DEPTH))
   `SCFP_ASSERT_NEXT(a_eof_starts_walk, clock, reset, accept && frame_end, state_ff == S_CMD_RD)
   `SCFP_ASSERT_NEXT(a_ready_sets_link, clock, reset, accept && hs_done, rsp_valid && link_ff)
endmodule
`default_nettype wire
